FILE: rtl/ipsc_pkg.sv
// Shared types, codes and constants of the interlocked PI speed controller.
`timescale 1ns / 1ps
`default_nettype none
package ipsc_pkg;

  localparam int IPSC_NUM_PRESETS = 5;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] CFG_PERIOD      = 3'd2;
  localparam logic [2:0] CFG_KICK_DUTY   = 3'd3;
  localparam logic [2:0] CFG_DUTY_CEIL   = 3'd4;
  localparam logic [2:0] CFG_INTEG_LIMIT = 3'd5;
  localparam logic [2:0] CFG_PRESET_STEP = 3'd6;

  // Register reset values.
  localparam logic [15:0] RST_PROP_GAIN   = 16'd512;
  localparam logic [15:0] RST_INTEG_GAIN  = 16'd128;
  localparam logic [15:0] RST_PERIOD      = 16'd50;
  localparam logic [9:0]  RST_KICK_DUTY   = 10'd150;
  localparam logic [9:0]  RST_DUTY_CEIL   = 10'd999;
  localparam logic [19:0] RST_INTEG_LIMIT = 20'd500000;
  localparam logic [9:0]  RST_PRESET_STEP = 10'd50;

  // Duty is the numerator divided by 256000; 1024 times that saturates any duty.
  localparam logic [27:0] DIV_K   = 28'd256000;
  localparam logic [43:0] DIV_SAT = 44'd262144000;

  typedef enum logic [1:0] {
    MODE_LOCKED   = 2'd0,
    MODE_UNLOCKED = 2'd1,
    MODE_RUN      = 2'd2,
    MODE_FAULT    = 2'd3
  } ipsc_mode_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_LOCK   = 2'd1,
    CMD_UNLOCK = 2'd2
  } ipsc_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CTRL,
    ST_MUL1,
    ST_CLAMP,
    ST_MUL2,
    ST_COMB,
    ST_DIV,
    ST_EMIT
  } ipsc_state_t;

endpackage
`default_nettype wire

FILE: rtl/ipsc_if.sv
// Channel interfaces of the speed controller: tick input, result output, configuration.
`timescale 1ns / 1ps
`default_nettype none
interface ipsc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic        door_shut;
  logic        actuator_fault;
  logic        actuator_is_locked;
  logic        press_speed;
  logic        press_run;
  logic        press_lock;
  logic signed [15:0] shaft_speed_rpm;

  modport source (output valid, time_ms, door_shut, actuator_fault, actuator_is_locked,
                  press_speed, press_run, press_lock, shaft_speed_rpm, input ready);
  modport sink (input valid, time_ms, door_shut, actuator_fault, actuator_is_locked,
                press_speed, press_run, press_lock, shaft_speed_rpm, output ready);
endinterface

interface ipsc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        motor_on;
  logic [9:0]  pwm_duty;
  logic [1:0]  actuator_cmd;
  logic [12:0] preset_rpm;
  logic        fault_flag;

  modport source (output valid, mode, motor_on, pwm_duty, actuator_cmd, preset_rpm,
                  fault_flag, input ready);
  modport sink (input valid, mode, motor_on, pwm_duty, actuator_cmd, preset_rpm,
                fault_flag, output ready);
endinterface

interface ipsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/interlocked_pi_speed_controller.sv
// Top level of the interlocked PI speed controller with a digit-serial PI datapath.
`timescale 1ns / 1ps
`default_nettype none
//
//   channel  | direction | transfer when        | payload
//   in_ch    | sink      | valid && ready       | time, door, fault, lock state, buttons, speed
//   out_ch   | source    | valid && ready       | mode, motor, duty, actuator command, target, fault
//   cfg_ch   | sink      | valid (ready is high)| register index, write data
//
// A tick with no PI update goes from the control state straight to the emit state. A tick
// that runs the PI update passes through two 16-bit shift-add multiplies (error by
// elapsed time together with proportional gain by error, then integral gain by the
// integral) and a restoring division by 256000 that yields a 10-bit quotient; a numerator
// that is not positive or that saturates the duty skips the division.
// Reset is synchronous and active low; it restores the register defaults and the
// stopped-locked state. A new tick is taken only when the previous one has finished;
// a held result in the output register does not block the computation of the next.
module interlocked_pi_speed_controller
  import ipsc_pkg::*;
#(
  parameter int NUM_PRESETS = IPSC_NUM_PRESETS
) (
  input  wire        clk,
  input  wire        rst_n,
  ipsc_in_if.sink    in_ch,
  ipsc_out_if.source out_ch,
  ipsc_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic [15:0] prop_r, integ_g_r, period_r;
  logic [9:0]  kick_r, ceil_r, step_r;
  logic [19:0] lim_r;

  // Controller state.
  ipsc_state_t state_r, state_nxt;
  ipsc_mode_t  mode_r, mode_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [31:0] last_r, last_nxt;
  logic [9:0]  duty_r, duty_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Registered tick fields.
  logic [31:0] t_r, t_nxt;
  logic        door_r, door_nxt, fault_r, fault_nxt, lockd_r, lockd_nxt;
  logic        ps_r, ps_nxt, pr_r, pr_nxt, pl_r, pl_nxt;
  logic [15:0] spd_r, spd_nxt;

  // Serial datapath.
  logic [31:0] dt_r, dt_nxt;
  logic [15:0] erm_r, erm_nxt;
  logic        eneg_r, eneg_nxt;
  logic [47:0] prd_r, prd_nxt;
  logic [31:0] pp_r, pp_nxt;
  logic [41:0] pk_r, pk_nxt;
  logic [19:0] amag_r, amag_nxt;
  logic        aneg_r, aneg_nxt;
  logic [15:0] gm_r, gm_nxt;
  logic [35:0] ia_r, ia_nxt;
  logic [27:0] rem_r, rem_nxt;
  logic [9:0]  q_r, q_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  // Staged result fields.
  ipsc_cmd_t   cmd_r, cmd_nxt;
  logic [12:0] tgt_r, tgt_nxt;

  // Output register.
  ipsc_mode_t  o_mode_r, o_mode_nxt;
  logic        o_motor_r, o_motor_nxt;
  logic [9:0]  o_duty_r, o_duty_nxt;
  ipsc_cmd_t   o_cmd_r, o_cmd_nxt;
  logic [12:0] o_tgt_r, o_tgt_nxt;
  logic        o_fault_r, o_fault_nxt;

  // Interlock and button decisions for the registered tick.
  ipsc_mode_t  c_mode;
  logic [2:0]  c_idx;
  logic [9:0]  c_duty;
  logic        c_clr;
  ipsc_cmd_t   c_cmd;
  logic [3:0]  c_idx_p1;
  logic [13:0] tgt_full;
  logic [31:0] c_last, c_dt;
  logic        c_go;
  logic [15:0] spd_mag;
  logic [16:0] err17, err_neg17;

  // Integral clamp and numerator terms.
  logic [49:0] prod_s, sum50, lim50, neglim50;
  logic [20:0] acc_new, acc_neg;
  logic [43:0] n44;
  logic [27:0] dsh;
  logic        rem_ge;
  logic [9:0]  q_step;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.mode         = o_mode_r;
  assign out_ch.motor_on     = o_motor_r;
  assign out_ch.pwm_duty     = o_duty_r;
  assign out_ch.actuator_cmd = o_cmd_r;
  assign out_ch.preset_rpm   = o_tgt_r;
  assign out_ch.fault_flag   = o_fault_r;

  // The interlocks and buttons are applied in a fixed order: fault, door, speed preset,
  // start/stop, then lock/unlock. Each step sees the mode the previous one left.
  always_comb begin
    c_mode = mode_r;
    c_idx  = idx_r;
    c_duty = duty_r;
    c_clr  = 1'b0;
    c_cmd  = CMD_NONE;
    if (fault_r) begin
      c_duty = '0;
      c_clr  = 1'b1;
      c_mode = MODE_FAULT;
    end
    if (!door_r && c_mode == MODE_RUN) begin
      c_duty = '0;
      c_clr  = 1'b1;
      c_mode = MODE_LOCKED;
    end
    if (ps_r && c_mode != MODE_RUN) begin
      c_idx = idx_r + 3'd1;
      if ({1'b0, c_idx} >= 4'(NUM_PRESETS)) begin
        c_idx = '0;
      end
    end
    if (pr_r) begin
      if (c_mode == MODE_RUN) begin
        c_duty = '0;
        c_clr  = 1'b1;
        c_mode = lockd_r ? MODE_LOCKED : MODE_UNLOCKED;
      end else if (c_mode == MODE_LOCKED || c_mode == MODE_UNLOCKED) begin
        if (!door_r) begin
          c_duty = '0;
        end else if (fault_r) begin
          c_duty = '0;
          c_mode = MODE_FAULT;
        end else begin
          c_clr  = 1'b1;
          c_duty = (kick_r > ceil_r) ? ceil_r : kick_r;
          c_mode = MODE_RUN;
        end
      end else if (!fault_r) begin
        c_mode = MODE_LOCKED;
      end
    end
    if (pl_r && c_mode != MODE_RUN && c_mode != MODE_FAULT) begin
      if (lockd_r) begin
        c_cmd  = CMD_UNLOCK;
        c_mode = MODE_UNLOCKED;
      end else begin
        c_cmd  = CMD_LOCK;
        c_mode = MODE_LOCKED;
      end
    end
  end

  // Target speed, elapsed time and the speed error for the PI update.
  assign c_idx_p1  = {1'b0, c_idx} + 4'd1;
  assign tgt_full  = {10'd0, c_idx_p1} * {4'd0, step_r};
  assign c_last    = c_clr ? t_r : last_r;
  assign c_dt      = t_r - c_last;
  assign c_go      = (c_mode == MODE_RUN) && (c_dt >= {16'd0, period_r});
  assign spd_mag   = spd_r[15] ? (~spd_r + 16'd1) : spd_r;
  assign err17     = {4'd0, tgt_full[12:0]} - {1'b0, spd_mag};
  assign err_neg17 = 17'd0 - err17;

  // The integral is clamped to the symmetric limit after adding error times elapsed time.
  assign prod_s   = eneg_r ? (50'd0 - {2'd0, prd_r}) : {2'd0, prd_r};
  assign sum50    = {{29{acc_r[20]}}, acc_r} + prod_s;
  assign lim50    = {30'd0, lim_r};
  assign neglim50 = 50'd0 - lim50;
  always_comb begin
    if ($signed(sum50) > $signed(lim50)) begin
      acc_new = lim50[20:0];
    end else if ($signed(sum50) < $signed(neglim50)) begin
      acc_new = neglim50[20:0];
    end else begin
      acc_new = sum50[20:0];
    end
  end
  assign acc_neg = 21'd0 - acc_new;

  // Signed numerator: proportional term (already times 1000) plus integral term.
  assign n44 = (eneg_r ? (44'd0 - {2'd0, pk_r}) : {2'd0, pk_r})
             + (aneg_r ? (44'd0 - {8'd0, ia_r}) : {8'd0, ia_r});

  // One quotient bit per cycle, most significant first.
  assign dsh    = DIV_K << cnt_r;
  assign rem_ge = (rem_r >= dsh);
  assign q_step = {q_r[8:0], rem_ge};

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    last_nxt      = last_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    t_nxt         = t_r;
    door_nxt      = door_r;
    fault_nxt     = fault_r;
    lockd_nxt     = lockd_r;
    ps_nxt        = ps_r;
    pr_nxt        = pr_r;
    pl_nxt        = pl_r;
    spd_nxt       = spd_r;
    dt_nxt        = dt_r;
    erm_nxt       = erm_r;
    eneg_nxt      = eneg_r;
    prd_nxt       = prd_r;
    pp_nxt        = pp_r;
    pk_nxt        = pk_r;
    amag_nxt      = amag_r;
    aneg_nxt      = aneg_r;
    gm_nxt        = gm_r;
    ia_nxt        = ia_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    cmd_nxt       = cmd_r;
    tgt_nxt       = tgt_r;
    o_mode_nxt    = o_mode_r;
    o_motor_nxt   = o_motor_r;
    o_duty_nxt    = o_duty_r;
    o_cmd_nxt     = o_cmd_r;
    o_tgt_nxt     = o_tgt_r;
    o_fault_nxt   = o_fault_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          t_nxt     = in_ch.time_ms;
          door_nxt  = in_ch.door_shut;
          fault_nxt = in_ch.actuator_fault;
          lockd_nxt = in_ch.actuator_is_locked;
          ps_nxt    = in_ch.press_speed;
          pr_nxt    = in_ch.press_run;
          pl_nxt    = in_ch.press_lock;
          spd_nxt   = in_ch.shaft_speed_rpm;
          state_nxt = ST_CTRL;
        end
      end
      ST_CTRL: begin
        mode_nxt = c_mode;
        idx_nxt  = c_idx;
        duty_nxt = c_duty;
        acc_nxt  = c_clr ? 21'd0 : acc_r;
        last_nxt = c_go ? t_r : c_last;
        cmd_nxt  = c_cmd;
        tgt_nxt  = tgt_full[12:0];
        dt_nxt   = c_dt;
        eneg_nxt = err17[16];
        erm_nxt  = err17[16] ? err_neg17[15:0] : err17[15:0];
        prd_nxt  = '0;
        pp_nxt   = '0;
        cnt_nxt  = '0;
        state_nxt = c_go ? ST_MUL1 : ST_EMIT;
      end
      ST_MUL1: begin
        prd_nxt = {prd_r[46:0], 1'b0} + (erm_r[15] ? {16'd0, dt_r} : 48'd0);
        pp_nxt  = {pp_r[30:0], 1'b0} + (erm_r[15] ? {16'd0, prop_r} : 32'd0);
        erm_nxt = {erm_r[14:0], 1'b0};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        acc_nxt  = acc_new;
        aneg_nxt = acc_new[20];
        amag_nxt = acc_new[20] ? acc_neg[19:0] : acc_new[19:0];
        pk_nxt   = {pp_r, 10'd0} - {6'd0, pp_r, 4'd0} - {7'd0, pp_r, 3'd0};
        gm_nxt   = integ_g_r;
        ia_nxt   = '0;
        cnt_nxt  = '0;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        ia_nxt  = {ia_r[34:0], 1'b0} + (gm_r[15] ? {16'd0, amag_r} : 36'd0);
        gm_nxt  = {gm_r[14:0], 1'b0};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          state_nxt = ST_COMB;
        end
      end
      ST_COMB: begin
        if (n44[43] || n44 == 44'd0) begin
          duty_nxt  = '0;
          state_nxt = ST_EMIT;
        end else if (n44 >= DIV_SAT) begin
          duty_nxt  = ceil_r;
          state_nxt = ST_EMIT;
        end else begin
          rem_nxt   = n44[27:0];
          q_nxt     = '0;
          cnt_nxt   = 4'd9;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? (rem_r - dsh) : rem_r;
        q_nxt   = q_step;
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          duty_nxt  = (q_step > ceil_r) ? ceil_r : q_step;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          o_mode_nxt    = mode_r;
          o_motor_nxt   = (mode_r == MODE_RUN);
          o_duty_nxt    = (mode_r == MODE_RUN) ? duty_r : 10'd0;
          o_cmd_nxt     = cmd_r;
          o_tgt_nxt     = tgt_r;
          o_fault_nxt   = fault_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control state and the configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_LOCKED;
      idx_r       <= '0;
      acc_r       <= '0;
      last_r      <= '0;
      duty_r      <= '0;
      out_valid_r <= 1'b0;
      prop_r      <= RST_PROP_GAIN;
      integ_g_r   <= RST_INTEG_GAIN;
      period_r    <= RST_PERIOD;
      kick_r      <= RST_KICK_DUTY;
      ceil_r      <= RST_DUTY_CEIL;
      lim_r       <= RST_INTEG_LIMIT;
      step_r      <= RST_PRESET_STEP;
    end else begin
      mode_r      <= mode_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      last_r      <= last_nxt;
      duty_r      <= duty_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          CFG_PROP_GAIN:   prop_r    <= cfg_ch.data[15:0];
          CFG_INTEG_GAIN:  integ_g_r <= cfg_ch.data[15:0];
          CFG_PERIOD:      period_r  <= cfg_ch.data[15:0];
          CFG_KICK_DUTY:   kick_r    <= cfg_ch.data[9:0];
          CFG_DUTY_CEIL:   ceil_r    <= cfg_ch.data[9:0];
          CFG_INTEG_LIMIT: lim_r     <= cfg_ch.data;
          CFG_PRESET_STEP: step_r    <= cfg_ch.data[9:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    door_r    <= door_nxt;
    fault_r   <= fault_nxt;
    lockd_r   <= lockd_nxt;
    ps_r      <= ps_nxt;
    pr_r      <= pr_nxt;
    pl_r      <= pl_nxt;
    spd_r     <= spd_nxt;
    dt_r      <= dt_nxt;
    erm_r     <= erm_nxt;
    eneg_r    <= eneg_nxt;
    prd_r     <= prd_nxt;
    pp_r      <= pp_nxt;
    pk_r      <= pk_nxt;
    amag_r    <= amag_nxt;
    aneg_r    <= aneg_nxt;
    gm_r      <= gm_nxt;
    ia_r      <= ia_nxt;
    rem_r     <= rem_nxt;
    q_r       <= q_nxt;
    cnt_r     <= cnt_nxt;
    cmd_r     <= cmd_nxt;
    tgt_r     <= tgt_nxt;
    o_mode_r  <= o_mode_nxt;
    o_motor_r <= o_motor_nxt;
    o_duty_r  <= o_duty_nxt;
    o_cmd_r   <= o_cmd_nxt;
    o_tgt_r   <= o_tgt_nxt;
    o_fault_r <= o_fault_nxt;
  end

`ifndef SYNTHESIS
  // A reported fault always leaves the block in the fault mode.
  a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_fault_r) |-> (o_mode_r == MODE_FAULT))
    else $error("fault reported outside fault mode");

  // Lock and unlock pulses only go out from a stopped mode.
  a_cmd_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_cmd_r != CMD_NONE) |->
    (o_mode_r == MODE_LOCKED || o_mode_r == MODE_UNLOCKED))
    else $error("actuator pulse outside a stopped mode");

  // The motor is driven exactly when running, and the duty is zero whenever it is not.
  a_motor_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_motor_r == (o_mode_r == MODE_RUN)) && (o_motor_r || o_duty_r == 10'd0))
    else $error("motor or duty inconsistent with mode");

  // A new result is loaded only when the output register is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_valid_r && !out_ch.ready) |=> (state_r == ST_EMIT))
    else $error("result overwrote a pending transfer");
`endif

endmodule
`default_nettype wire
